FILE: rtl/tgad_pkg.sv
// ----------------------------------------------------------------------------
// tgad_pkg
// Shared types and constants of the TGA image decoder.
// ----------------------------------------------------------------------------
package tgad_pkg;

    localparam logic [1:0] KIND_OK     = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_UNSUP  = 2'd2;
    localparam logic [1:0] KIND_PIXEL  = 2'd3;

    localparam logic [4:0] HDR_ID_LEN     = 5'd0;
    localparam logic [4:0] HDR_IMAGE_TYPE = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
    localparam logic [4:0] HDR_PIXEL_BITS = 5'd16;
    localparam logic [4:0] HDR_LAST       = 5'd17;

    localparam logic [7:0] TYPE_TRUECOLOR     = 8'd2;
    localparam logic [7:0] TYPE_RLE_TRUECOLOR = 8'd10;

    localparam logic [7:0] BITS_8  = 8'd8;
    localparam logic [7:0] BITS_24 = 8'd24;
    localparam logic [7:0] BITS_32 = 8'd32;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [2:0]  pixel_bytes;
        logic [31:0] pixel;
        logic [7:0]  run;
        logic [31:0] first_index;
        logic        done;
        logic        overrun;
    } result_t;

endpackage

FILE: rtl/tgad_out_reg.sv
// ----------------------------------------------------------------------------
// tgad_out_reg
// Output register of the decoder; holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module tgad_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tgad_pkg::result_t result_in,
    input  logic              take,
    output logic              full,
    output logic              can_load,
    output tgad_pkg::result_t result_out
);

    logic              valid_reg;
    logic              valid_next;
    tgad_pkg::result_t data_reg;

    assign can_load   = !valid_reg || take;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);
    assign full       = valid_reg;
    assign result_out = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

endmodule

FILE: rtl/tga_image_rle_decoder.sv
// ----------------------------------------------------------------------------
// tga_image_rle_decoder
// Decodes a TGA file stream (types 2 and 10) into header reports and pixel runs.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  s_*     | in        | tdata: file byte; tuser: start of file
//  m_*     | out       | tdata: header fields and pixel run; tuser: kind, overrun;
//          |           | tlast: image complete
//
//  One file byte is accepted per cycle when not stalled; the result it causes
//  appears in the output register in the next cycle. The per-byte state update
//  is one short pass; width times height is formed by one 16x16 multiply on
//  header byte 16. After reset the decoder expects header bytes. The input is
//  stalled only while the output register holds a result the sink does not take.
// ----------------------------------------------------------------------------
module tga_image_rle_decoder
#(
    parameter int PIXEL_INDEX_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,  // [7:0] data_byte
    input  logic         s_tuser,  // [0] start_of_file
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,  // [15:0] image_width, [31:16] image_height,
                                   // [34:32] bytes_per_pixel, [66:35] pixel_value,
                                   // [74:67] run_length, [106:75] first_pixel_index,
                                   // [111:107] zero
    output logic [2:0]   m_tuser,  // [1:0] result_kind, [2] overrun
    output logic         m_tlast   // image_done
);

    localparam int IW = PIXEL_INDEX_BITS;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_IDSKIP  = 3'd1;
    localparam logic [2:0] PH_PLAIN   = 3'd2;
    localparam logic [2:0] PH_PKTHDR  = 3'd3;
    localparam logic [2:0] PH_PKTDATA = 3'd4;
    localparam logic [2:0] PH_STOPPED = 3'd5;

    logic [2:0]    phase_reg, phase_next;
    logic [4:0]    hdr_count_reg, hdr_count_next;
    logic [7:0]    id_left_reg, id_left_next;
    logic [7:0]    image_type_reg, image_type_next;
    logic [15:0]   width_reg, width_next;
    logic [15:0]   height_reg, height_next;
    logic [2:0]    pixel_bytes_reg, pixel_bytes_next;
    logic [IW-1:0] total_reg, total_next;
    logic [IW-1:0] current_reg, current_next;
    logic [7:0]    packet_left_reg, packet_left_next;
    logic          packet_run_reg, packet_run_next;
    logic          packet_clip_reg, packet_clip_next;
    logic [31:0]   assembly_reg, assembly_next;
    logic [1:0]    byte_idx_reg, byte_idx_next;
    logic [31:0]   product_reg, product_next;

    logic              accept;
    logic              emit;
    logic              out_can_load;
    tgad_pkg::result_t result;
    tgad_pkg::result_t out_result;

    logic [7:0]    b;
    logic [1:0]    byte_idx_inc;
    logic          pixel_complete;
    logic [7:0]    pkt_count;
    logic [IW-1:0] remaining;
    logic [7:0]    run;
    logic [IW-1:0] current_sum;
    logic [2:0]    data_phase;

    assign s_tready = out_can_load;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    always_comb
    begin
        phase_next       = phase_reg;
        hdr_count_next   = hdr_count_reg;
        id_left_next     = id_left_reg;
        image_type_next  = image_type_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        pixel_bytes_next = pixel_bytes_reg;
        total_next       = total_reg;
        current_next     = current_reg;
        packet_left_next = packet_left_reg;
        packet_run_next  = packet_run_reg;
        packet_clip_next = packet_clip_reg;
        assembly_next    = assembly_reg;
        byte_idx_next    = byte_idx_reg;
        product_next     = product_reg;
        emit             = 1'b0;
        result           = '0;
        byte_idx_inc     = '0;
        pixel_complete   = 1'b0;
        pkt_count        = '0;
        remaining        = '0;
        run              = '0;
        current_sum      = '0;
        data_phase       = PH_PKTHDR;

        if (accept)
        begin
            if (s_tuser)
            begin
                phase_next       = PH_HEADER;
                hdr_count_next   = '0;
                id_left_next     = '0;
                image_type_next  = '0;
                width_next       = '0;
                height_next      = '0;
                pixel_bytes_next = '0;
                total_next       = '0;
                current_next     = '0;
                packet_left_next = '0;
                packet_run_next  = 1'b0;
                packet_clip_next = 1'b0;
                assembly_next    = '0;
                byte_idx_next    = '0;
            end

            data_phase = (image_type_next == tgad_pkg::TYPE_TRUECOLOR) ? PH_PLAIN : PH_PKTHDR;

            byte_idx_inc = byte_idx_next + 2'd1;
            pixel_complete = (pixel_bytes_next == 3'd0) ||
                             (byte_idx_inc == pixel_bytes_next[1:0]);

            case (phase_next)
                PH_HEADER:
                begin
                    case (hdr_count_next)
                        tgad_pkg::HDR_ID_LEN:     id_left_next = b;
                        tgad_pkg::HDR_IMAGE_TYPE: image_type_next = b;
                        tgad_pkg::HDR_WIDTH_LO:   width_next[7:0] = b;
                        tgad_pkg::HDR_WIDTH_HI:   width_next[15:8] = b;
                        tgad_pkg::HDR_HEIGHT_LO:  height_next[7:0] = b;
                        tgad_pkg::HDR_HEIGHT_HI:  height_next[15:8] = b;
                        tgad_pkg::HDR_PIXEL_BITS:
                        begin
                            product_next = 32'(width_next) * 32'(height_next);
                            case (b)
                                tgad_pkg::BITS_8:  pixel_bytes_next = 3'd1;
                                tgad_pkg::BITS_24: pixel_bytes_next = 3'd3;
                                tgad_pkg::BITS_32: pixel_bytes_next = 3'd4;
                                default:           pixel_bytes_next = 3'd0;
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                    if (hdr_count_next < tgad_pkg::HDR_LAST)
                    begin
                        hdr_count_next = hdr_count_next + 5'd1;
                    end
                    else
                    begin
                        hdr_count_next = '0;
                        emit = 1'b1;
                        if (width_next == 16'd0 || height_next == 16'd0 ||
                            pixel_bytes_next == 3'd0 || (product_reg >> IW) != 32'd0)
                        begin
                            result.kind = tgad_pkg::KIND_REJECT;
                            phase_next  = PH_STOPPED;
                        end
                        else if (image_type_next != tgad_pkg::TYPE_TRUECOLOR &&
                                 image_type_next != tgad_pkg::TYPE_RLE_TRUECOLOR)
                        begin
                            result.kind = tgad_pkg::KIND_UNSUP;
                            phase_next  = PH_STOPPED;
                        end
                        else
                        begin
                            result.kind   = tgad_pkg::KIND_OK;
                            total_next    = product_reg[IW-1:0];
                            current_next  = '0;
                            byte_idx_next = '0;
                            phase_next    = (id_left_next != 8'd0) ? PH_IDSKIP : data_phase;
                        end
                    end
                end
                PH_IDSKIP:
                begin
                    if (id_left_next != 8'd0)
                    begin
                        id_left_next = id_left_next - 8'd1;
                    end
                    if (id_left_next == 8'd0)
                    begin
                        phase_next = data_phase;
                    end
                end
                PH_PLAIN, PH_PKTDATA:
                begin
                    if (byte_idx_next == 2'd0)
                    begin
                        assembly_next = {24'd0, b};
                    end
                    else
                    begin
                        assembly_next = assembly_next | (32'(b) << {byte_idx_next, 3'b000});
                    end
                    byte_idx_next = pixel_complete ? 2'd0 : byte_idx_inc;
                    if (pixel_complete)
                    begin
                        emit = 1'b1;
                        run  = (phase_next == PH_PKTDATA && packet_run_next) ?
                               packet_left_next : 8'd1;
                        current_sum = current_next + IW'(run);
                        result.kind        = tgad_pkg::KIND_PIXEL;
                        result.pixel       = assembly_next;
                        result.run         = run;
                        result.first_index = 32'(current_next);
                        result.done        = (current_sum >= total_next);
                        current_next = current_sum;
                        if (phase_next == PH_PKTDATA)
                        begin
                            packet_left_next = packet_left_next - run;
                            result.overrun   = packet_clip_next && (packet_left_next == 8'd0);
                            if (result.done)
                            begin
                                phase_next = PH_STOPPED;
                            end
                            else if (packet_left_next == 8'd0)
                            begin
                                phase_next = PH_PKTHDR;
                            end
                        end
                        else if (result.done)
                        begin
                            phase_next = PH_STOPPED;
                        end
                    end
                end
                PH_PKTHDR:
                begin
                    pkt_count = b[7] ? (b - 8'd127) : (b + 8'd1);
                    remaining = total_next - current_next;
                    packet_run_next = b[7];
                    if (IW'(pkt_count) > remaining)
                    begin
                        packet_left_next = remaining[7:0];
                        packet_clip_next = 1'b1;
                    end
                    else
                    begin
                        packet_left_next = pkt_count;
                        packet_clip_next = 1'b0;
                    end
                    byte_idx_next = '0;
                    phase_next    = PH_PKTDATA;
                end
                default:
                begin
                end
            endcase

            result.width       = width_next;
            result.height      = height_next;
            result.pixel_bytes = pixel_bytes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            hdr_count_reg   <= '0;
            id_left_reg     <= '0;
            image_type_reg  <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            pixel_bytes_reg <= '0;
            total_reg       <= '0;
            current_reg     <= '0;
            packet_left_reg <= '0;
            packet_run_reg  <= 1'b0;
            packet_clip_reg <= 1'b0;
            assembly_reg    <= '0;
            byte_idx_reg    <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            hdr_count_reg   <= hdr_count_next;
            id_left_reg     <= id_left_next;
            image_type_reg  <= image_type_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            pixel_bytes_reg <= pixel_bytes_next;
            total_reg       <= total_next;
            current_reg     <= current_next;
            packet_left_reg <= packet_left_next;
            packet_run_reg  <= packet_run_next;
            packet_clip_reg <= packet_clip_next;
            assembly_reg    <= assembly_next;
            byte_idx_reg    <= byte_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    tgad_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit),
        .result_in  (result),
        .take       (m_tready),
        .full       (m_tvalid),
        .can_load   (out_can_load),
        .result_out (out_result)
    );

    assign m_tdata = {5'd0, out_result.first_index, out_result.run, out_result.pixel,
                      out_result.pixel_bytes, out_result.height, out_result.width};
    assign m_tuser = {out_result.overrun, out_result.kind};
    assign m_tlast = out_result.done;

    // An empty output register never holds back the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // A packet in progress always has pixels left.
    a_packet_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PKTDATA) |-> (packet_left_reg != 8'd0))
        else $error("packet data phase with no pixels left");

    // While decoding pixel data the index stays inside the image.
    a_index_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PLAIN || phase_reg == PH_PKTHDR || phase_reg == PH_PKTDATA)
        |-> (current_reg < total_reg))
        else $error("pixel index reached the image size while decoding");

    // A packet header always starts on a pixel boundary.
    a_pkthdr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PKTHDR) |-> (byte_idx_reg == 2'd0))
        else $error("packet header inside a pixel");

endmodule
